// ===== design/qeb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_pkg
// Shared widths, lookup tables and codes for the quadrature encoder block.
// ----------------------------------------------------------------------------
package qeb_pkg;

    localparam int COUNT_WIDTH      = 16;
    localparam int STEPS_PER_DETENT = 4;
    localparam int THRESH_WIDTH     = 16;

    // Wide enough for both the press count and the threshold.
    localparam int CMP_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

    // The step counter must hold -STEPS_PER_DETENT..+STEPS_PER_DETENT.
    localparam int STEP_WIDTH = $clog2(STEPS_PER_DETENT) + 2;

    // Indexed by {new B, new A, previous B, previous A}.
    localparam logic [15:0] UP_TABLE   = 16'h2814;
    localparam logic [15:0] DOWN_TABLE = 16'h4182;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(50);

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } t_rotation;

endpackage

// ===== design/qeb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_in_if
// Sample channel: one item carries the button and the A/B line levels.
// ----------------------------------------------------------------------------
interface qeb_in_if;
    logic valid;
    logic ready;
    logic btn_level;
    logic phase_a_level;
    logic phase_b_level;

    modport source (output valid, output btn_level, output phase_a_level,
                    output phase_b_level, input ready);
    modport sink   (input valid, input btn_level, input phase_a_level,
                    input phase_b_level, output ready);
endinterface

// ===== design/qeb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_out_if
// Result channel: one item carries the click flag and the rotation code.
// ----------------------------------------------------------------------------
interface qeb_out_if;
    logic       valid;
    logic       ready;
    logic       click;
    logic [1:0] rotation;

    modport source (output valid, output click, output rotation, input ready);
    modport sink   (input valid, input click, input rotation, output ready);
endinterface

// ===== design/qeb_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_cfg_if
// Configuration write channel for the press threshold register.
// ----------------------------------------------------------------------------
interface qeb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/quadrature_encoder_with_button_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_core
// Rotary encoder decoder with push-button click detection.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch carries one sampled tick per item: button, A and B line levels.
//   o_out_ch returns exactly one item per tick: a click flag and a rotation
//   code (none, clockwise detent, counter-clockwise detent).
//   i_cfg_ch writes the press threshold; it is always ready and should only
//   be written while no tick is in flight.
// Timing:
//   The decoder state and the output register both load at the edge that
//   accepts a tick, so the result is offered from the next cycle. One tick
//   is accepted every cycle while the output register is empty or being
//   drained; the state update is a single table lookup plus a small add.
// Flow control:
//   The input is ready whenever the output register is empty or is being
//   drained in the same cycle. A stalled receiver holds the result and the
//   input stalls with it; nothing is dropped.
// Reset:
//   Synchronous active-low reset empties the output register, sets the
//   threshold to 50 ticks, marks the button released and clears both the
//   press count and the step counter.
// ----------------------------------------------------------------------------
module quadrature_encoder_with_button_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qeb_in_if.sink    i_in_ch,
    qeb_out_if.source o_out_ch,
    qeb_cfg_if.sink   i_cfg_ch
);

    logic [qeb_pkg::THRESH_WIDTH-1:0] r_threshold;
    logic                             r_out_valid;
    logic                             r_click;
    qeb_pkg::t_rotation               r_rotation;

    logic                             w_accept;
    logic                             w_click;
    qeb_pkg::t_rotation               w_rotation;

    assign i_in_ch.ready  = !r_out_valid || o_out_ch.ready;
    assign w_accept       = i_in_ch.valid && i_in_ch.ready;
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= qeb_pkg::THRESH_RESET;
        end else if (i_cfg_ch.valid) begin
            r_threshold <= i_cfg_ch.data;
        end
    end

    qeb_button u_button (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_btn_level (i_in_ch.btn_level),
        .i_threshold (r_threshold),
        .o_click     (w_click)
    );

    qeb_rotary u_rotary (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_phase_a_level (i_in_ch.phase_a_level),
        .i_phase_b_level (i_in_ch.phase_b_level),
        .o_rotation      (w_rotation)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_click    <= w_click;
            r_rotation <= w_rotation;
        end
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.click    = r_click;
    assign o_out_ch.rotation = r_rotation;

endmodule

// ===== design/qeb_button.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_button
// Counts low button ticks; clicks on a level change once count >= threshold.
// ----------------------------------------------------------------------------
module qeb_button (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_btn_level,
    input  logic [qeb_pkg::THRESH_WIDTH-1:0]  i_threshold,
    output logic                              o_click
);

    logic                             r_last_btn;
    logic [qeb_pkg::COUNT_WIDTH-1:0]  r_press_ticks;
    logic [qeb_pkg::COUNT_WIDTH-1:0]  n_press_ticks;
    logic [qeb_pkg::COUNT_WIDTH-1:0]  w_incr;
    logic                             w_change;

    // The count saturates instead of wrapping.
    assign w_incr = (!i_btn_level && (r_press_ticks != '1)) ?
                    r_press_ticks + qeb_pkg::COUNT_WIDTH'(1) : r_press_ticks;
    assign w_change = (i_btn_level != r_last_btn);

    always_comb begin
        o_click       = 1'b0;
        n_press_ticks = w_incr;
        if (w_change) begin
            o_click       = (qeb_pkg::CMP_WIDTH'(w_incr) >=
                             qeb_pkg::CMP_WIDTH'(i_threshold));
            n_press_ticks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_btn    <= 1'b1;
            r_press_ticks <= '0;
        end else if (i_accept) begin
            r_last_btn    <= i_btn_level;
            r_press_ticks <= n_press_ticks;
        end
    end

endmodule

// ===== design/qeb_rotary.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeb_rotary
// Table-driven quadrature decoder with a per-detent step counter.
// ----------------------------------------------------------------------------
module qeb_rotary (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_phase_a_level,
    input  logic               i_phase_b_level,
    output qeb_pkg::t_rotation o_rotation
);

    localparam logic signed [qeb_pkg::STEP_WIDTH-1:0] STEP_MAX =
        qeb_pkg::STEP_WIDTH'(qeb_pkg::STEPS_PER_DETENT);
    localparam logic signed [qeb_pkg::STEP_WIDTH-1:0] STEP_MIN = -STEP_MAX;
    localparam logic signed [qeb_pkg::STEP_WIDTH-1:0] STEP_ONE =
        qeb_pkg::STEP_WIDTH'(1);

    logic [1:0]                              r_prev_phase;
    logic signed [qeb_pkg::STEP_WIDTH-1:0]   r_step_count;
    logic signed [qeb_pkg::STEP_WIDTH-1:0]   n_step_count;
    logic signed [qeb_pkg::STEP_WIDTH-1:0]   w_stepped;
    logic [3:0]                              w_idx;

    assign w_idx = {i_phase_b_level, i_phase_a_level, r_prev_phase};

    // Transitions that are in neither table leave the counter alone.
    always_comb begin
        priority if (qeb_pkg::UP_TABLE[w_idx]) begin
            w_stepped = r_step_count + STEP_ONE;
        end else if (qeb_pkg::DOWN_TABLE[w_idx]) begin
            w_stepped = r_step_count - STEP_ONE;
        end else begin
            w_stepped = r_step_count;
        end
    end

    always_comb begin
        o_rotation   = qeb_pkg::ROT_NONE;
        n_step_count = w_stepped;
        priority if (w_stepped >= STEP_MAX) begin
            o_rotation   = qeb_pkg::ROT_CW;
            n_step_count = '0;
        end else if (w_stepped <= STEP_MIN) begin
            o_rotation   = qeb_pkg::ROT_CCW;
            n_step_count = '0;
        end else begin
            n_step_count = w_stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= 2'b00;
            r_step_count <= '0;
        end else if (i_accept) begin
            r_prev_phase <= {i_phase_b_level, i_phase_a_level};
            r_step_count <= n_step_count;
        end
    end

endmodule

// ===== sim/tb_quadrature_encoder_with_button_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_with_button_core
// Drives sample ticks into the encoder block, predicts the click flag and the
// rotation code of every tick, and checks each result item in order.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_with_button_core;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_SEGMENTS  = 9;
    localparam int SEG_ITEMS     = 95;
    localparam int LONG_HOLD     = 60;
    localparam int PRESS_CAP     = 200;

    typedef struct {
        bit                 click;
        qeb_pkg::t_rotation rotation;
    } t_tick_result;

    // Tracks the decoder state and holds the expected results in order.
    class tick_scoreboard;
        logic [qeb_pkg::THRESH_WIDTH-1:0] threshold;
        bit                               last_btn;
        logic [qeb_pkg::COUNT_WIDTH-1:0]  press_ticks;
        logic [1:0]                       prev_ab;
        int                               step_count;
        t_tick_result                     expected_ticks[$];
        int                               mismatches;

        function new();
            threshold   = qeb_pkg::THRESH_RESET;
            last_btn    = 1'b1;
            press_ticks = '0;
            prev_ab     = 2'b00;
            step_count  = 0;
            mismatches  = 0;
        endfunction

        function void set_threshold(logic [qeb_pkg::THRESH_WIDTH-1:0] value);
            threshold = value;
        endfunction

        function void predict_tick(bit btn, bit a, bit b);
            t_tick_result res;
            logic [3:0]   idx;
            res.click    = 1'b0;
            res.rotation = qeb_pkg::ROT_NONE;
            if (!btn && press_ticks != '1) begin
                press_ticks = press_ticks + 1'b1;
            end
            if (btn != last_btn) begin
                if (qeb_pkg::CMP_WIDTH'(press_ticks) >=
                    qeb_pkg::CMP_WIDTH'(threshold)) begin
                    res.click = 1'b1;
                end
                press_ticks = '0;
            end
            last_btn = btn;

            idx = {b, a, prev_ab};
            if (qeb_pkg::UP_TABLE[idx]) begin
                step_count++;
            end else if (qeb_pkg::DOWN_TABLE[idx]) begin
                step_count--;
            end
            prev_ab = {b, a};
            if (step_count >= qeb_pkg::STEPS_PER_DETENT) begin
                res.rotation = qeb_pkg::ROT_CW;
                step_count   = 0;
            end else if (step_count <= -qeb_pkg::STEPS_PER_DETENT) begin
                res.rotation = qeb_pkg::ROT_CCW;
                step_count   = 0;
            end
            expected_ticks.push_back(res);
        endfunction

        function void check_result(bit click, logic [1:0] rotation);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result item click=%0d rotation=%0d",
                             $realtime, click, rotation);
                end
                return;
            end
            want = expected_ticks.pop_front();
            if (want.click !== click || want.rotation !== rotation) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch: expected click=%0d rotation=%0d,",
                             $realtime, want.click, want.rotation,
                             " got click=%0d rotation=%0d", click, rotation);
                end
            end
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    qeb_in_if  in_ch();
    qeb_out_if out_ch();
    qeb_cfg_if cfg_ch();

    quadrature_encoder_with_button_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    tick_scoreboard sb = new();

    bit  idle_on   = 1'b1;
    int  sink_hold = 0;
    int  cycle_count = 0;
    int  cur_thr   = int'(qeb_pkg::THRESH_RESET);

    // Generator state for the random part.
    int  gen_pos  = 0;
    int  gen_dir  = 1;
    bit  gen_btn  = 1'b1;
    int  gen_left = 0;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[quadrature_encoder_with_button_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.predict_tick(in_ch.btn_level, in_ch.phase_a_level, in_ch.phase_b_level);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.click, out_ch.rotation);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end else if (idle_on) begin
                stall = $urandom_range(0, 15);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Gray order of (B, A): 00, 01, 11, 10; stepping forward counts up.
    function automatic logic [1:0] ba_of_pos(int pos);
        case (pos & 3)
            0:       return 2'b00;
            1:       return 2'b01;
            2:       return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    task automatic send_tick(bit btn, bit a, bit b);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.btn_level     <= btn;
        in_ch.phase_a_level <= a;
        in_ch.phase_b_level <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_pos(bit btn, int pos);
        logic [1:0] ba;
        ba = ba_of_pos(pos);
        send_tick(btn, ba[0], ba[1]);
    endtask

    // Waits on the clock before polling, so the item accepted at the last edge is already queued.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [qeb_pkg::THRESH_WIDTH-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.set_threshold(value);
        cur_thr = int'(value);
    endtask

    // Mostly clean rotation and press sequences, with some line noise.
    task automatic random_tick();
        int r;
        int span;
        if (gen_left == 0) begin
            gen_btn = !gen_btn;
            if (!gen_btn) begin
                span = (cur_thr > PRESS_CAP) ? PRESS_CAP : cur_thr;
                case ($urandom_range(0, 5))
                    0:       gen_left = $urandom_range(1, 2);
                    1:       gen_left = span;
                    2:       gen_left = span + 1;
                    3:       gen_left = span + 2;
                    default: gen_left = $urandom_range(1, 2 * span + 4);
                endcase
                if (gen_left == 0) begin
                    gen_left = 1;
                end
            end else begin
                gen_left = $urandom_range(1, 10);
            end
        end
        gen_left--;

        r = $urandom_range(0, 99);
        if (r < 10) begin
            gen_pos = $urandom_range(0, 3);
        end else if (r < 28) begin
            if (r < 20) begin
                gen_dir = -gen_dir;
            end
            gen_pos = (gen_pos + gen_dir + 4) % 4;
        end else if (r >= 35) begin
            gen_pos = (gen_pos + gen_dir + 4) % 4;
        end
        send_pos(gen_btn, gen_pos);
    endtask

    initial begin : stimulus
        int seg;
        int i;
        logic [qeb_pkg::THRESH_WIDTH-1:0] thr;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.btn_level     <= 1'b1;
        in_ch.phase_a_level <= 1'b0;
        in_ch.phase_b_level <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one detent each way, then invalid jumps and a held phase.
        send_pos(1'b1, 1); send_pos(1'b1, 2); send_pos(1'b1, 3); send_pos(1'b1, 0);
        send_pos(1'b1, 3); send_pos(1'b1, 2); send_pos(1'b1, 1); send_pos(1'b1, 0);
        send_pos(1'b1, 2); send_pos(1'b1, 2); send_pos(1'b1, 0);
        // Short press below the reset threshold.
        send_pos(1'b0, 0); send_pos(1'b0, 0); send_pos(1'b0, 0); send_pos(1'b1, 0);

        // Zero threshold: both the press and the release report a click.
        wait_drained();
        write_threshold('0);
        send_pos(1'b0, 0); send_pos(1'b1, 0);

        // Threshold of two: the press edge tick is not counted; three low ticks click, two do not.
        wait_drained();
        write_threshold(qeb_pkg::THRESH_WIDTH'(2));
        send_pos(1'b0, 1); send_pos(1'b0, 1); send_pos(1'b0, 1); send_pos(1'b1, 1);
        send_pos(1'b0, 1); send_pos(1'b0, 1); send_pos(1'b1, 1);
        gen_pos = 1;

        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            wait_drained();
            case (seg)
                0:       thr = '0;
                1:       thr = qeb_pkg::THRESH_WIDTH'(1);
                2:       thr = '1;
                3:       thr = qeb_pkg::THRESH_WIDTH'(3);
                default: thr = qeb_pkg::THRESH_WIDTH'($urandom_range(2, 40));
            endcase
            write_threshold(thr);
            idle_on = ($urandom_range(0, 3) != 0);
            if (seg == 1) begin
                // The sender keeps offering items while the receiver holds off.
                idle_on   = 1'b1;
                sink_hold = LONG_HOLD;
            end
            for (i = 0; i < SEG_ITEMS; i++) begin
                random_tick();
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[quadrature_encoder_with_button_core] OK");
        end else begin
            $display("[quadrature_encoder_with_button_core] ERROR");
        end
        $finish;
    end
endmodule

// ===== quadrature_encoder_with_button_core.f =====
design/qeb_pkg.sv
design/qeb_in_if.sv
design/qeb_out_if.sv
design/qeb_cfg_if.sv
design/qeb_button.sv
design/qeb_rotary.sv
design/quadrature_encoder_with_button_core.sv
sim/tb_quadrature_encoder_with_button_core.sv
